// ----- src/svt_pkg.sv -----
// ----------------------------------------------------------------------------
// svt_pkg
// Shared constants for the strand vertex tangent block.
// ----------------------------------------------------------------------------
package svt_pkg;

    localparam int POSITION_BITS_DEF = 24;
    localparam int MAX_VERTICES_DEF  = 64;

    localparam int TAN_BITS   = 16;
    localparam int IDX_BITS   = 6;
    localparam int VPS_BITS   = 7;
    localparam int THR_BITS   = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_VPS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THR = 2'd1;

    localparam logic [VPS_BITS-1:0] VPS_RESET = 7'd16;
    localparam logic [THR_BITS-1:0] THR_RESET = 16'd1;
    localparam logic [VPS_BITS-1:0] VPS_MIN   = 7'd4;

    // magnitudes are reduced below 2^A_BITS before the length is taken
    localparam int A_BITS    = 16;
    localparam int LEN_BITS  = 34;
    localparam int REM_BITS  = 35;
    localparam int SUB_BITS  = 36;
    localparam int QUO_BITS  = 32;
    localparam int DIV_STEPS = 31;
    localparam int SQRT_STEPS = 16;

endpackage

// ----- src/strand_vertex_tangent.sv -----
// ----------------------------------------------------------------------------
// strand_vertex_tangent
// Per-vertex unit tangents of hair strands from streamed vertex positions.
// ----------------------------------------------------------------------------
// The first vertex of a strand is stored at its accept edge and produces no
// item; the input stays ready. The second vertex of a strand runs one
// normalization, every later vertex two, on a single shared restoring
// compare/subtract unit and one 16x16 multiplier. A normalization runs a load
// step, the halving loop and its exit, a multiply-accumulate of each squared
// component into the squared length, one threshold check, then per component
// one square, 31 divide steps and 16 square root steps, and a finish step. A
// vector whose squared length is at or below the threshold skips the
// per-component work. A segment needs up to POSITION_BITS-16 halvings (8 at
// the default width); the sum of two unit directions needs none. The input is
// not ready while a vertex is in progress, also while the output is stalled;
// a strand's last vertex also passes through a second emit state. The tangent
// of a vertex is emitted one vertex late; a strand's last vertex emits two
// items.
// ----------------------------------------------------------------------------
module strand_vertex_tangent #(
    parameter int POSITION_BITS       = svt_pkg::POSITION_BITS_DEF,
    parameter int MAX_STRAND_VERTICES = svt_pkg::MAX_VERTICES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic signed [POSITION_BITS-1:0]   i_pos_x,
    input  logic signed [POSITION_BITS-1:0]   i_pos_y,
    input  logic signed [POSITION_BITS-1:0]   i_pos_z,
    input  logic                              i_final_vertex,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic signed [svt_pkg::TAN_BITS-1:0] o_tan_x,
    output logic signed [svt_pkg::TAN_BITS-1:0] o_tan_y,
    output logic signed [svt_pkg::TAN_BITS-1:0] o_tan_z,
    output logic [svt_pkg::IDX_BITS-1:0]      o_vertex_in_strand,
    output logic                              o_strand_end,
    output logic                              o_set_end,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [svt_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [svt_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import svt_pkg::*;

    localparam int PB = POSITION_BITS;
    localparam int DW = POSITION_BITS + 1;
    localparam int CW = $clog2(MAX_STRAND_VERTICES);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_LOAD  = 4'd1;
    localparam logic [3:0] S_SHIFT = 4'd2;
    localparam logic [3:0] S_LEN   = 4'd3;
    localparam logic [3:0] S_ZCHK  = 4'd4;
    localparam logic [3:0] S_SQ    = 4'd5;
    localparam logic [3:0] S_DIV   = 4'd6;
    localparam logic [3:0] S_SQRT  = 4'd7;
    localparam logic [3:0] S_NDONE = 4'd8;
    localparam logic [3:0] S_EMIT1 = 4'd9;
    localparam logic [3:0] S_EMIT2 = 4'd10;
    localparam logic [3:0] S_FIN   = 4'd11;

    logic [3:0]                 r_state;
    logic [4:0]                 r_cnt;
    logic [1:0]                 r_comp;
    logic                       r_pass;
    logic [VPS_BITS-1:0]        r_vps;
    logic [THR_BITS-1:0]        r_thr;
    logic [CW-1:0]              r_vcnt;
    logic signed [PB-1:0]       r_pos [3];
    logic signed [TAN_BITS-1:0] r_dir [3];
    logic signed [PB-1:0]       r_in  [3];
    logic                       r_fin;
    logic [DW-1:0]              r_mag [3];
    logic                       r_neg [3];
    logic [LEN_BITS-1:0]        r_len2;
    logic [REM_BITS-1:0]        r_rem;
    logic [QUO_BITS-1:0]        r_quo;
    logic [A_BITS-1:0]          r_root;
    logic signed [TAN_BITS-1:0] r_res [3];
    logic signed [TAN_BITS-1:0] r_u   [3];

    logic                       r_ov;
    logic signed [TAN_BITS-1:0] r_ot [3];
    logic [IDX_BITS-1:0]        r_oidx;
    logic                       r_oend;
    logic                       r_oset;

    logic                       in_acc;
    logic                       can_load;
    logic                       out_load;
    logic [VPS_BITS-1:0]        n_eff;
    logic                       is_last;
    logic signed [DW-1:0]       vec [3];
    logic [DW-1:0]              vmag [3];
    logic                       big_hi;
    logic [A_BITS-1:0]          mul_a;
    logic [2*A_BITS-1:0]        prod;
    logic [SUB_BITS-1:0]        sub_a;
    logic [SUB_BITS-1:0]        sub_b;
    logic [SUB_BITS-1:0]        diff;
    logic                       ge;
    logic [REM_BITS-1:0]        div_trial;
    logic [REM_BITS-1:0]        sq_rem2;
    logic [REM_BITS-1:0]        sq_trial;
    logic [A_BITS-1:0]          root_nx;
    logic [A_BITS:0]            mid_w;
    logic signed [TAN_BITS-1:0] mid_s;

    assign in_acc      = i_in_valid && o_in_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign can_load    = !r_ov || i_out_ready;
    assign out_load    = ((r_state == S_EMIT1) || (r_state == S_EMIT2)) && can_load;

    always_comb begin
        n_eff = r_vps;
        if (r_vps < VPS_MIN) begin
            n_eff = VPS_MIN;
        end else if (r_vps > VPS_BITS'(MAX_STRAND_VERTICES)) begin
            n_eff = VPS_BITS'(MAX_STRAND_VERTICES);
        end
    end
    assign is_last = VPS_BITS'(r_vcnt) >= (n_eff - VPS_BITS'(1));

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (r_pass) begin
                vec[i] = DW'(r_dir[i]) + DW'(r_u[i]);
            end else begin
                vec[i] = DW'(r_in[i]) - DW'(r_pos[i]);
            end
            vmag[i] = vec[i][DW-1] ? DW'(~vec[i] + DW'(1)) : DW'(vec[i]);
        end
    end

    assign big_hi = (|r_mag[0][DW-1:A_BITS]) || (|r_mag[1][DW-1:A_BITS])
                 || (|r_mag[2][DW-1:A_BITS]);

    always_comb begin
        unique case (r_comp)
            2'd0:    mul_a = r_mag[0][A_BITS-1:0];
            2'd1:    mul_a = r_mag[1][A_BITS-1:0];
            default: mul_a = r_mag[2][A_BITS-1:0];
        endcase
    end
    assign prod = mul_a * mul_a;

    // shared compare/subtract unit
    assign div_trial = (r_cnt == 5'd0) ? r_rem : {r_rem[REM_BITS-2:0], 1'b0};
    assign sq_rem2   = {r_rem[REM_BITS-3:0], r_quo[QUO_BITS-1:QUO_BITS-2]};
    assign sq_trial  = REM_BITS'({r_root, 2'b01});
    always_comb begin
        if (r_state == S_DIV) begin
            sub_a = SUB_BITS'(div_trial);
            sub_b = SUB_BITS'(r_len2);
        end else begin
            sub_a = SUB_BITS'(sq_rem2);
            sub_b = SUB_BITS'(sq_trial);
        end
    end
    assign diff    = sub_a - sub_b;
    assign ge      = !diff[SUB_BITS-1];
    assign root_nx = {r_root[A_BITS-2:0], ge};
    assign mid_w   = ({1'b0, root_nx} + (A_BITS+1)'(1)) >> 1;
    assign mid_s   = TAN_BITS'(mid_w);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vps <= VPS_RESET;
            r_thr <= THR_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == CFG_VPS) begin
                r_vps <= i_cfg_data[VPS_BITS-1:0];
            end else if (i_cfg_index == CFG_THR) begin
                r_thr <= i_cfg_data[THR_BITS-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (out_load) begin
            r_ov <= 1'b1;
        end else if (i_out_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_vcnt  <= '0;
            r_cnt   <= '0;
            r_comp  <= '0;
            r_pass  <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                r_pos[i] <= '0;
                r_dir[i] <= '0;
            end
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_in[0] <= i_pos_x;
                        r_in[1] <= i_pos_y;
                        r_in[2] <= i_pos_z;
                        r_fin   <= i_final_vertex;
                        if (r_vcnt == '0) begin
                            r_pos[0] <= i_pos_x;
                            r_pos[1] <= i_pos_y;
                            r_pos[2] <= i_pos_z;
                            r_vcnt   <= CW'(1);
                        end else begin
                            r_pass  <= 1'b0;
                            r_state <= S_LOAD;
                        end
                    end
                end
                S_LOAD: begin
                    for (int i = 0; i < 3; i++) begin
                        r_mag[i] <= vmag[i];
                        r_neg[i] <= vec[i][DW-1];
                    end
                    r_len2  <= '0;
                    r_comp  <= '0;
                    r_state <= S_SHIFT;
                end
                S_SHIFT: begin
                    if (big_hi) begin
                        for (int i = 0; i < 3; i++) begin
                            r_mag[i] <= r_mag[i] >> 1;
                        end
                    end else begin
                        r_state <= S_LEN;
                    end
                end
                S_LEN: begin
                    r_len2 <= r_len2 + LEN_BITS'(prod);
                    if (r_comp == 2'd2) begin
                        r_comp  <= '0;
                        r_state <= S_ZCHK;
                    end else begin
                        r_comp <= r_comp + 2'd1;
                    end
                end
                S_ZCHK: begin
                    if (r_len2 <= LEN_BITS'(r_thr)) begin
                        for (int i = 0; i < 3; i++) begin
                            r_res[i] <= '0;
                        end
                        r_state <= S_NDONE;
                    end else begin
                        r_state <= S_SQ;
                    end
                end
                S_SQ: begin
                    r_rem   <= REM_BITS'(prod);
                    r_quo   <= '0;
                    r_cnt   <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_quo <= {r_quo[QUO_BITS-2:0], ge};
                    if (r_cnt == 5'(DIV_STEPS - 1)) begin
                        r_rem   <= '0;
                        r_root  <= '0;
                        r_cnt   <= '0;
                        r_state <= S_SQRT;
                    end else begin
                        r_rem <= ge ? diff[REM_BITS-1:0] : div_trial;
                        r_cnt <= r_cnt + 5'd1;
                    end
                end
                S_SQRT: begin
                    r_rem  <= ge ? diff[REM_BITS-1:0] : sq_rem2;
                    r_root <= root_nx;
                    r_quo  <= {r_quo[QUO_BITS-3:0], 2'b00};
                    r_cnt  <= r_cnt + 5'd1;
                    if (r_cnt == 5'(SQRT_STEPS - 1)) begin
                        unique case (r_comp)
                            2'd0:    r_res[0] <= r_neg[0] ? -mid_s : mid_s;
                            2'd1:    r_res[1] <= r_neg[1] ? -mid_s : mid_s;
                            default: r_res[2] <= r_neg[2] ? -mid_s : mid_s;
                        endcase
                        if (r_comp == 2'd2) begin
                            r_comp  <= '0;
                            r_state <= S_NDONE;
                        end else begin
                            r_comp  <= r_comp + 2'd1;
                            r_state <= S_SQ;
                        end
                    end
                end
                S_NDONE: begin
                    if (!r_pass) begin
                        for (int i = 0; i < 3; i++) begin
                            r_u[i] <= r_res[i];
                        end
                        if (r_vcnt == CW'(1)) begin
                            r_state <= S_EMIT1;
                        end else begin
                            r_pass  <= 1'b1;
                            r_state <= S_LOAD;
                        end
                    end else begin
                        r_state <= S_EMIT1;
                    end
                end
                S_EMIT1: begin
                    if (can_load) begin
                        for (int i = 0; i < 3; i++) begin
                            r_ot[i] <= r_res[i];
                        end
                        r_oidx  <= IDX_BITS'(r_vcnt - CW'(1));
                        r_oend  <= 1'b0;
                        r_oset  <= 1'b0;
                        r_state <= is_last ? S_EMIT2 : S_FIN;
                    end
                end
                S_EMIT2: begin
                    if (can_load) begin
                        for (int i = 0; i < 3; i++) begin
                            r_ot[i] <= r_u[i];
                        end
                        r_oidx  <= IDX_BITS'(r_vcnt);
                        r_oend  <= 1'b1;
                        r_oset  <= r_fin;
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    for (int i = 0; i < 3; i++) begin
                        r_pos[i] <= r_in[i];
                        r_dir[i] <= r_u[i];
                    end
                    r_vcnt  <= is_last ? '0 : r_vcnt + CW'(1);
                    r_pass  <= 1'b0;
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid        = r_ov;
    assign o_tan_x            = r_ot[0];
    assign o_tan_y            = r_ot[1];
    assign o_tan_z            = r_ot[2];
    assign o_vertex_in_strand = r_oidx;
    assign o_strand_end       = r_oend;
    assign o_set_end          = r_oset;

endmodule
